/* sv/button_debounce_note_events_top_assert.svh */
// Assertion macros for the button debounce block.
// Each macro checks an implication on the rising clock edge and is
// switched off while the active-low reset is asserted.
`ifndef BUTTON_DEBOUNCE_NOTE_EVENTS_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_NOTE_EVENTS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BDNE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdne: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define BDNE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdne: next-cycle check failed");
`else
`define BDNE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BDNE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/bdne_pkg.sv */
package bdne_pkg;

  typedef enum logic [1:0] {
    KIND_OFF    = 2'd0,
    KIND_ON     = 2'd1,
    KIND_STATUS = 2'd2
  } event_kind_e;

  // Only the first sixteen buttons have an input level.
  localparam int unsigned InButtons = 16;

  localparam logic [3:0] REG_DEBOUNCE_MS   = 4'd0;
  localparam logic [3:0] REG_NOTE_VELOCITY = 4'd1;
  localparam logic [3:0] REG_MIDI_CHANNEL  = 4'd2;
  localparam logic [3:0] REG_LED_HOLD_MS   = 4'd3;

  localparam logic [15:0] DebounceReset = 16'd20;
  localparam logic [6:0]  VelocityReset = 7'd127;
  localparam logic [4:0]  ChannelReset  = 5'd1;
  localparam logic [15:0] LedHoldReset  = 16'd50;

  typedef struct packed {
    logic [7:0]  buttons_low_raw;
    logic [7:0]  buttons_high_raw;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [3:0]  button_index;
    logic [6:0]  velocity;
    logic [4:0]  channel;
    logic        led_lit;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic        eval;
    logic [31:0] now_ms;
    logic [15:0] debounce_ms;
  } lane_ctl_t;

  typedef struct packed {
    logic change;
    logic on;
  } lane_res_t;

  typedef struct packed {
    logic        load;
    logic [31:0] now_ms;
    logic [6:0]  velocity;
    logic [4:0]  channel;
    logic [15:0] led_hold_ms;
  } merge_ctl_t;

  typedef struct packed {
    logic active;
    logic done;
  } merge_stat_t;

endpackage

/* sv/bdne_chan_if.sv */
interface bdne_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/bdne_lane.sv */
module bdne_lane
  import bdne_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  logic      pressed_i,
  output lane_res_t res_o
);

  logic        held_q, held_d;
  logic [31:0] stamp_q, stamp_d;
  logic [31:0] elapsed;

  // Wrap-safe elapsed time since this button last changed.
  assign elapsed      = ctl_i.now_ms - stamp_q;
  assign res_o.change = (pressed_i != held_q) && (elapsed > {16'd0, ctl_i.debounce_ms});
  assign res_o.on     = pressed_i;

  always_comb begin
    held_d  = held_q;
    stamp_d = stamp_q;
    if (ctl_i.eval && res_o.change) begin
      held_d  = pressed_i;
      stamp_d = ctl_i.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      stamp_q <= '0;
    end else begin
      held_q  <= held_d;
      stamp_q <= stamp_d;
    end
  end

endmodule

/* sv/bdne_merge.sv */
module bdne_merge
  import bdne_pkg::*;
#(
  parameter int unsigned Buttons = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  merge_ctl_t         ctl_i,
  input  logic [Buttons-1:0] change_i,
  input  logic [Buttons-1:0] on_i,
  bdne_chan_if.source        out_ch_o,
  output merge_stat_t        stat_o
);

  localparam int unsigned IdxW = (Buttons > 1) ? $clog2(Buttons) : 1;

  logic [Buttons-1:0] pend_q, pend_d;
  logic [Buttons-1:0] on_q, on_d;
  logic [Buttons-1:0] low;
  logic [IdxW-1:0]    idx;
  logic               sel_on;
  logic               active_q, active_d;
  logic               led_q, led_d;
  logic [31:0]        led_stamp_q, led_stamp_d;
  logic [31:0]        led_elapsed;
  logic               led_expire;
  logic [31:0]        now_q, now_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;
  logic               step;

  // Lowest pending button first, so events leave in index order.
  assign low    = pend_q & (~pend_q + 1'b1);
  assign sel_on = |(low & on_q);

  always_comb begin
    idx = '0;
    for (int i = 0; i < Buttons; i++) begin
      if (low[i]) begin
        idx = idx | IdxW'(i);
      end
    end
  end

  assign led_elapsed = now_q - led_stamp_q;
  assign led_expire  = led_elapsed > {16'd0, ctl_i.led_hold_ms};
  assign slot_free   = !out_valid_q || out_ch_o.ready;
  assign step        = active_q && slot_free;

  always_comb begin
    pend_d        = pend_q;
    on_d          = on_q;
    now_d         = now_q;
    active_d      = active_q;
    led_d         = led_q;
    led_stamp_d   = led_stamp_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ch_o.ready;
    stat_o.active = active_q;
    stat_o.done   = 1'b0;
    if (ctl_i.load) begin
      pend_d   = change_i;
      on_d     = on_i;
      now_d    = ctl_i.now_ms;
      active_d = 1'b1;
    end else if (step) begin
      out_valid_d      = 1'b1;
      out_d.channel    = ctl_i.channel;
      if (|pend_q) begin
        pend_d             = pend_q & ~low;
        out_d.button_index = 4'(idx);
        out_d.last         = 1'b0;
        if (sel_on) begin
          led_d            = 1'b1;
          led_stamp_d      = now_q;
          out_d.event_kind = KIND_ON;
          out_d.velocity   = ctl_i.velocity;
          out_d.led_lit    = 1'b1;
        end else begin
          out_d.event_kind = KIND_OFF;
          out_d.velocity   = '0;
          out_d.led_lit    = led_q;
        end
      end else begin
        led_d              = led_q && !led_expire;
        out_d.event_kind   = KIND_STATUS;
        out_d.button_index = '0;
        out_d.velocity     = '0;
        out_d.led_lit      = led_d;
        out_d.last         = 1'b1;
        active_d           = 1'b0;
        stat_o.done        = 1'b1;
      end
    end
  end

  assign out_ch_o.valid   = out_valid_q;
  assign out_ch_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      on_q        <= '0;
      active_q    <= 1'b0;
      led_q       <= 1'b0;
      led_stamp_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      on_q        <= on_d;
      active_q    <= active_d;
      led_q       <= led_d;
      led_stamp_q <= led_stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    out_q <= out_d;
  end

endmodule

/* sv/button_debounce_note_events_top.sv */
// Button scanner with per-button lockout debounce, producing note events.
// Channels: in_ch_i takes one scan item (sixteen active-low button levels and
// the millisecond time of the scan); out_ch_o gives note-off, note-on and
// status items; cfg_ch_i writes the four registers and is always ready.
// On the cycle a scan item is accepted, every button lane compares its level
// with its held note state and checks its lockout time, all in parallel.
// The merging stage then issues one event per cycle while the receiver keeps up,
// lowest button first, and closes the scan with a status item that carries the LED state.
// The first result item enters the output register after the merging stage is loaded.
// A scan with n changes gives n events and one status item; the pace is set by
// the single output register, which the merging stage fills one item a cycle
// while the receiver takes them.
// A new scan is taken as soon as the status item of the previous one sits in
// the output register, even while that item still waits to be taken.
// When the receiver stalls, the output register holds its item and the
// merging stage waits; no item is lost or repeated.
// Reset clears all held notes, change times, the LED and restores the
// register defaults; the block is ready in the first cycle after reset.
`include "button_debounce_note_events_top_assert.svh"

module button_debounce_note_events_top
  import bdne_pkg::*;
#(
  parameter int unsigned BUTTONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdne_chan_if.sink   in_ch_i,
  bdne_chan_if.source out_ch_o,
  bdne_chan_if.sink   cfg_ch_i
);

  logic [15:0] debounce_q;
  logic [6:0]  velocity_q;
  logic [4:0]  channel_q;
  logic [15:0] led_hold_q;

  logic busy_q, busy_d;
  logic in_acc;
  logic cfg_acc;

  logic [15:0]        levels;
  logic [BUTTONS-1:0] pressed;
  logic [BUTTONS-1:0] change;
  logic [BUTTONS-1:0] on;
  lane_ctl_t          lane_ctl;
  lane_res_t          lane_res [BUTTONS];
  merge_ctl_t         merge_ctl;
  merge_stat_t        merge_stat;

  // Register writes are always taken; an index outside the list is ignored.
  assign cfg_ch_i.ready = 1'b1;
  assign cfg_acc        = cfg_ch_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
      velocity_q <= VelocityReset;
      channel_q  <= ChannelReset;
      led_hold_q <= LedHoldReset;
    end else if (cfg_acc) begin
      case (cfg_ch_i.payload.index)
        REG_DEBOUNCE_MS:   debounce_q <= cfg_ch_i.payload.data;
        REG_NOTE_VELOCITY: velocity_q <= cfg_ch_i.payload.data[6:0];
        REG_MIDI_CHANNEL:  channel_q  <= cfg_ch_i.payload.data[4:0];
        REG_LED_HOLD_MS:   led_hold_q <= cfg_ch_i.payload.data;
        default: begin
        end
      endcase
    end
  end

  // One scan at a time: busy from acceptance until its status item is issued.
  assign in_ch_i.ready = !busy_q;
  assign in_acc        = in_ch_i.valid && !busy_q;

  always_comb begin
    busy_d = busy_q;
    if (in_acc) begin
      busy_d = 1'b1;
    end else if (merge_stat.done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Lanes evaluate straight from the accepted scan item.
  assign levels = {in_ch_i.payload.buttons_high_raw, in_ch_i.payload.buttons_low_raw};

  assign lane_ctl.eval        = in_acc;
  assign lane_ctl.now_ms      = in_ch_i.payload.now_ms;
  assign lane_ctl.debounce_ms = debounce_q;

  for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
    // Buttons beyond the input width read as released and never change.
    if (g < InButtons) begin : g_wired
      assign pressed[g] = ~levels[g];
    end else begin : g_open
      assign pressed[g] = 1'b0;
    end

    bdne_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lane_ctl),
      .pressed_i (pressed[g]),
      .res_o     (lane_res[g])
    );

    assign change[g] = lane_res[g].change;
    assign on[g]     = lane_res[g].on;
  end

  assign merge_ctl.load        = in_acc;
  assign merge_ctl.now_ms      = in_ch_i.payload.now_ms;
  assign merge_ctl.velocity    = velocity_q;
  assign merge_ctl.channel     = channel_q;
  assign merge_ctl.led_hold_ms = led_hold_q;

  bdne_merge #(
    .Buttons (BUTTONS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (merge_ctl),
    .change_i (change),
    .on_i     (on),
    .out_ch_o (out_ch_o),
    .stat_o   (merge_stat)
  );

  // A new scan must never land on a merging stage that is still issuing.
  `BDNE_ASSERT_NOW(a_load_when_idle, clk_i, rst_ni, merge_ctl.load, !merge_stat.active)
  // After a scan is taken the input is closed in the next cycle.
  `BDNE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ch_i.ready)
  // A note-on item always shows the activity LED lit.
  `BDNE_ASSERT_NOW(a_on_lights_led, clk_i, rst_ni,
                   out_ch_o.valid && (out_ch_o.payload.event_kind == KIND_ON),
                   out_ch_o.payload.led_lit)
  // The last flag marks the status item and nothing else.
  `BDNE_ASSERT_NOW(a_last_is_status, clk_i, rst_ni, out_ch_o.valid,
                   out_ch_o.payload.last == (out_ch_o.payload.event_kind == KIND_STATUS))

endmodule
